/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the classifier RTL. Sampled on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define BAC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the cycle after
`define BAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// expr never holds
`define BAC_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

/* hdl/bac_pkg.sv */
// ----------------------------------------------------------------------------
// bac_pkg
// Types and constants of the BLE advertising address classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bac_pkg;

  // Address octets that lead every frame; AD data follows them.
  localparam int unsigned ADDRESS_BYTES = 6;

  // Beacon-like AD types: manufacturer data, 16-bit and 128-bit service data.
  localparam logic [7:0] AD_TYPE_MFR_DATA   = 8'hFF;
  localparam logic [7:0] AD_TYPE_SVC_DATA16 = 8'h16;
  localparam logic [7:0] AD_TYPE_SVC_DATA128 = 8'h21;

  // Shortest AD data that is walked at all.
  localparam logic [7:0] MIN_AD_BYTES = 8'd3;

  // Configuration port
  localparam int unsigned CFG_DATA_W = 8;
  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_PERSIST_MIN     = 1'b0;
  localparam cfg_index_t CFG_BEACON_REQUIRED = 1'b1;

  localparam logic [7:0] PERSIST_MIN_RST     = 8'd3;
  localparam logic       BEACON_REQUIRED_RST = 1'b1;

  typedef enum logic [2:0] {
    CLS_TENTATIVE = 3'd0,
    CLS_STATIC    = 3'd1,
    CLS_NRPA      = 3'd2,
    CLS_RPA       = 3'd3,
    CLS_PUBLIC    = 3'd4,
    CLS_WIFI      = 3'd5
  } cls_t;

  // Random address subtype, address_msb[7:6]
  typedef enum logic [1:0] {
    SUB_NRPA     = 2'b00,
    SUB_RPA      = 2'b01,
    SUB_RESERVED = 2'b10,
    SUB_STATIC   = 2'b11
  } rand_sub_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       byte_last;
    logic [7:0] frame_length;
    logic       is_wifi;
    logic       addr_public;
    logic [7:0] address_msb;
    logic [7:0] sighting_count;
    logic [2:0] prior_class;
    logic       broadcast_only;
  } frame_item_t;

  typedef struct packed {
    logic [2:0] address_class;
    logic       replay_eligible;
    logic       beacon_hit;
  } result_item_t;

endpackage

`default_nettype wire

/* hdl/bac_stream_if.sv */
// ----------------------------------------------------------------------------
// bac_stream_if
// Valid/ready channel carrying one item of type payload_t.
// ----------------------------------------------------------------------------
`default_nettype none

interface bac_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/ble_adv_address_classifier_core.sv */
// ----------------------------------------------------------------------------
// ble_adv_address_classifier_core
// Walks the AD structures of a captured advertising frame, one byte per item,
// and on the last byte emits the address class, replay eligibility and the
// beacon flag.
// ----------------------------------------------------------------------------
//
//   channel   dir   payload          items
//   frame     in    frame_item_t     one per frame byte, byte_last on final
//   result    out   result_item_t    one per record, after its last byte
//   cfg_*     in    index + 8b data  persist_min, beacon_required
//
// Cycles: one item per cycle sustained when not stalled. An item waits in the
// input register, where the walker and the classifier see it; a result appears
// on the output register in the cycle after its last byte leaves it.
// Reset: rst (sync) empties both registers, clears the walk state and loads
// persist_min = 3, beacon_required = 1.
// Stalls: the output register holds a result while result.ready is low;
// frame keeps taking non-last bytes, and stops only when a last byte would
// need the occupied output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_adv_address_classifier_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  bac_stream_if.sink                  frame,
  bac_stream_if.source                result,
  input  wire logic                   cfg_write,
  input  wire bac_pkg::cfg_index_t    cfg_index,
  input  wire logic [bac_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bac_pkg::*;

  // configuration registers
  logic [7:0]  persist_min;
  logic        beacon_required;

  // input register
  logic        s1_valid;
  frame_item_t s1_item;
  logic        s1_adv;       // item leaves the input register this cycle
  logic        accept;

  logic        beacon_found;
  logic        res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      persist_min     <= PERSIST_MIN_RST;
      beacon_required <= BEACON_REQUIRED_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PERSIST_MIN:     persist_min     <= cfg_data[7:0];
        CFG_BEACON_REQUIRED: beacon_required <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // a non-last byte always moves on; a last byte needs room for its result
  assign s1_adv      = s1_valid && (!s1_item.byte_last || res_free);
  assign frame.ready = !s1_valid || s1_adv;
  assign accept      = frame.valid && frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_item <= frame.data;
  end

  bac_walker u_walker (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_adv),
    .byte_last    (s1_item.byte_last),
    .frame_byte   (s1_item.frame_byte),
    .frame_length (s1_item.frame_length),
    .beacon_found (beacon_found)
  );

  bac_result u_result (
    .clk             (clk),
    .rst             (rst),
    .load            (s1_adv && s1_item.byte_last),
    .item            (s1_item),
    .beacon_found    (beacon_found),
    .persist_min     (persist_min),
    .beacon_required (beacon_required),
    .free            (res_free),
    .result          (result)
  );

  `include "assert_macros.svh"

  `BAC_ASSERT_IMP(a_stall_cause, !frame.ready, s1_valid && s1_item.byte_last && result.valid, "input stalled without a held last byte")
  `BAC_ASSERT_NEXT(a_hold_item, s1_valid && !s1_adv, s1_valid && $stable(s1_item), "held item lost")

endmodule

`default_nettype wire

/* hdl/bac_walker.sv */
// ----------------------------------------------------------------------------
// bac_walker
// AD length/type walk over the bytes of one record; flags beacon-like types.
// ----------------------------------------------------------------------------
`default_nettype none

module bac_walker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,          // one byte consumed this cycle
  input  wire logic       byte_last,
  input  wire logic [7:0] frame_byte,
  input  wire logic [7:0] frame_length,
  output logic            beacon_found   // walk result including this byte
);
  import bac_pkg::*;

  localparam logic [7:0] ADDR_B = 8'(ADDRESS_BYTES);

  logic [7:0] byte_position, byte_position_next;
  logic [7:0] field_start, field_start_next;
  logic       expect_type, expect_type_next;
  logic       walk_stopped, walk_stopped_next;
  logic       found_beacon, found_beacon_next;

  logic [7:0] ad_len;
  logic [7:0] ad_pos;
  logic [8:0] hdr_end;
  logic       walk_active;
  logic       hdr_bad;
  logic       beacon_type;

  assign ad_len  = frame_length - ADDR_B;
  assign ad_pos  = byte_position - ADDR_B;
  assign hdr_end = {1'b0, ad_pos} + 9'd1 + {1'b0, frame_byte};

  assign walk_active = (byte_position >= ADDR_B) && (frame_length > ADDR_B) &&
                       (ad_len >= MIN_AD_BYTES) && (ad_pos < ad_len) &&
                       !walk_stopped && !found_beacon;

  // header with no room for a type byte, zero length, or field past the end
  assign hdr_bad = ({1'b0, ad_pos} + 9'd1 >= {1'b0, ad_len}) ||
                   (frame_byte == 8'd0) || (hdr_end > {1'b0, ad_len});

  assign beacon_type = (frame_byte == AD_TYPE_MFR_DATA) ||
                       (frame_byte == AD_TYPE_SVC_DATA16) ||
                       (frame_byte == AD_TYPE_SVC_DATA128);

  always_comb begin
    field_start_next  = field_start;
    expect_type_next  = expect_type;
    walk_stopped_next = walk_stopped;
    found_beacon_next = found_beacon;
    if (walk_active) begin
      if (expect_type) begin
        expect_type_next = 1'b0;
        if (beacon_type) found_beacon_next = 1'b1;
      end else if (ad_pos == field_start) begin
        if (hdr_bad) begin
          walk_stopped_next = 1'b1;
        end else begin
          field_start_next = hdr_end[7:0];
          expect_type_next = 1'b1;
        end
      end
    end
    byte_position_next = (byte_position == 8'hFF) ? byte_position : byte_position + 8'd1;
  end

  assign beacon_found = found_beacon_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      field_start   <= '0;
      expect_type   <= 1'b0;
      walk_stopped  <= 1'b0;
      found_beacon  <= 1'b0;
    end else if (step) begin
      if (byte_last) begin
        byte_position <= '0;
        field_start   <= '0;
        expect_type   <= 1'b0;
        walk_stopped  <= 1'b0;
        found_beacon  <= 1'b0;
      end else begin
        byte_position <= byte_position_next;
        field_start   <= field_start_next;
        expect_type   <= expect_type_next;
        walk_stopped  <= walk_stopped_next;
        found_beacon  <= found_beacon_next;
      end
    end
  end

  `include "assert_macros.svh"

  `BAC_ASSERT_NEVER(a_type_after_stop, expect_type && walk_stopped, "type pending after stop")
  `BAC_ASSERT_NEXT(a_clear_on_last, step && byte_last, byte_position == 8'd0 && !found_beacon, "record state not cleared")

endmodule

`default_nettype wire

/* hdl/bac_result.sv */
// ----------------------------------------------------------------------------
// bac_result
// Address classification and the result register feeding the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bac_result (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire bac_pkg::frame_item_t item,
  input  wire logic                 beacon_found,
  input  wire logic [7:0]           persist_min,
  input  wire logic                 beacon_required,
  output logic                      free,
  bac_stream_if.source              result
);
  import bac_pkg::*;

  logic         stable;
  logic         payload_met;
  logic         promote;
  logic         repro;
  rand_sub_t    sub;
  cls_t         cls;
  result_item_t res_next;
  logic         res_valid;
  result_item_t res_data;

  assign stable      = item.sighting_count >= persist_min;
  assign payload_met = beacon_found || !beacon_required;
  assign promote     = stable && payload_met;
  assign sub         = rand_sub_t'(item.address_msb[7:6]);

  always_comb begin
    if (item.is_wifi) begin
      cls = CLS_WIFI;
    end else if (item.addr_public) begin
      cls = CLS_PUBLIC;
    end else begin
      case (sub)
        SUB_RPA: cls = CLS_RPA;
        SUB_NRPA: begin
          // sticky: once nrpa, stays nrpa
          cls = (promote || item.prior_class == CLS_NRPA) ? CLS_NRPA : CLS_TENTATIVE;
        end
        SUB_STATIC: begin
          cls = (promote || item.prior_class == CLS_STATIC) ? CLS_STATIC : CLS_TENTATIVE;
        end
        default: cls = CLS_TENTATIVE;
      endcase
    end
  end

  assign repro = (cls == CLS_STATIC) || (cls == CLS_NRPA) || (cls == CLS_WIFI);

  assign res_next.address_class   = cls;
  assign res_next.replay_eligible = stable && repro && (item.is_wifi || item.broadcast_only);
  assign res_next.beacon_hit      = beacon_found;

  assign free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_data <= res_next;
  end

  assign result.valid = res_valid;
  assign result.data  = res_data;

  `include "assert_macros.svh"

  `BAC_ASSERT_IMP(a_no_overwrite, load, !res_valid || result.ready, "result overwritten while held")

endmodule

`default_nettype wire
